// ----- src/running_sample_statistics_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Running sample statistics unit - assertion macros
// Shared property forms for the checks at the end of the RTL module.
// ----------------------------------------------------------------------------
`ifndef RUNNING_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg
// Widths and constants of the running sample statistics unit.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int DATA_W = 24;                                // Q16.8 sample
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);           // sample count
    localparam int SUM_W  = DATA_W + $clog2(MAX_SAMPLES);      // sum of times
    localparam int SQ_W   = 2 * DATA_W + $clog2(MAX_SAMPLES);  // sum of squares
    localparam int NUM_W  = SQ_W + CNT_W;                      // n*sumsq, sum^2
    localparam int NSQ_W  = 2 * CNT_W;                         // n^2
    localparam int VAR_W  = 2 * DATA_W;                        // variance bound
    localparam int REM_W  = DATA_W + 3;                        // shared remainder
    localparam int STEP_W = $clog2(SUM_W + VAR_W + 1);

    localparam int S_TDATA_W    = ((2 * DATA_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CNT_W + 4 * DATA_W;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ----- src/running_sample_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// running_sample_statistics_unit
// Count, truncated mean, population standard deviation and maxima over up
// to MAX_SAMPLES samples, worked out with bit-serial arithmetic.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata: time_in_bank, wait_time
//  m_*     | out | m_tvalid / m_tready | tdata: sample_count, mean, sd, maxima;
//          |     |                     | tuser: accepted
//
//  A recorded sample passes through accept, square, accumulate, sum^2 with
//  the mean division, n*sumsq with n^2, subtract, restoring divide, root
//  and unload, in that order.
//  A sample offered with the store full skips the square and accumulate.
//  One shift-add / restore-compare datapath, one bit (root: two) per cycle.
//  Reset clears all statistics at once; no clearing pass.
//  A new word is taken as soon as the sequencer is idle, even while the last
//  result waits in the output register; a result stalls only if that
//  register is still occupied.
//
`include "running_sample_statistics_unit_defines.svh"

module running_sample_statistics_unit
    import rss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata, from bit 0: time_in_bank[23:0], wait_time[47:24]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0: sample_count[10:0], mean_time[34:11],
    //   std_dev_time[58:35], max_time[82:59], max_wait[106:83], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: accepted
    output logic                 m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,   // t*t, multiplier bits MSB first
        ST_ACCUM,    // sumsq += t*t
        ST_MUL_SS,   // sum*sum, sum/n alongside
        ST_MUL_NS,   // n*sumsq, n*n alongside
        ST_SUB,      // numerator = n*sumsq - sum^2
        ST_DIVIDE,   // numerator / n^2
        ST_ROOT,     // floor square root, two bits a step
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // statistics
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   sumsq_reg, sumsq_next;
    logic [DATA_W-1:0] max_time_reg, max_time_next;
    logic [DATA_W-1:0] max_wait_reg, max_wait_next;

    // working registers
    logic [DATA_W-1:0] t_reg, t_next;
    logic              accepted_reg, accepted_next;
    logic [SUM_W-1:0]  mbits_reg, mbits_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic [NSQ_W-1:0]  nsq_reg, nsq_next;
    logic [CNT_W-1:0]  mrem_reg, mrem_next;
    logic [DATA_W-1:0] mean_reg, mean_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] root_reg, root_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_accepted_reg, out_accepted_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic [DATA_W-1:0] out_mean_reg, out_mean_next;
    logic [DATA_W-1:0] out_sd_reg, out_sd_next;
    logic [DATA_W-1:0] out_max_time_reg, out_max_time_next;
    logic [DATA_W-1:0] out_max_wait_reg, out_max_wait_next;

    // datapath terms
    logic [DATA_W-1:0] in_time, in_wait;
    logic              in_fire, count_full, out_free, mbit;
    logic [NUM_W-1:0]  prod_shift, acc_shift;
    logic [CNT_W:0]    mean_r, mean_d;
    logic              mean_ge;
    logic              num_ge;
    logic [REM_W-1:0]  div_r, div_d, sqrt_r, sqrt_trial;
    logic              div_ge, sqrt_ge;

    assign in_time    = s_tdata[DATA_W-1:0];
    assign in_wait    = s_tdata[2*DATA_W-1:DATA_W];
    assign in_fire    = s_tvalid && s_tready;
    assign count_full = count_reg >= CNT_W'(MAX_SAMPLES);
    assign out_free   = !out_valid_reg || m_tready;

    assign mbit       = mbits_reg[SUM_W-1];
    assign prod_shift = {prod_reg[NUM_W-2:0], 1'b0};
    assign acc_shift  = {acc_reg[NUM_W-2:0], 1'b0};

    // restoring divide of the sum by n, fed from the same bit stream
    assign mean_r  = {mrem_reg, mbit};
    assign mean_d  = {1'b0, count_reg};
    assign mean_ge = mean_r >= mean_d;

    // n*sumsq - sum^2, never negative but clamped anyway
    assign num_ge = acc_reg >= prod_reg;

    // restoring divide of the numerator by n^2
    assign div_r  = {rem_reg[REM_W-2:0], acc_reg[VAR_W-1]};
    assign div_d  = REM_W'(nsq_reg);
    assign div_ge = div_r >= div_d;

    // digit-by-digit square root
    assign sqrt_r     = {rem_reg[REM_W-3:0], acc_reg[VAR_W-1 -: 2]};
    assign sqrt_trial = REM_W'({root_reg, 2'b01});
    assign sqrt_ge    = sqrt_r >= sqrt_trial;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        sumsq_next        = sumsq_reg;
        max_time_next     = max_time_reg;
        max_wait_next     = max_wait_reg;
        t_next            = t_reg;
        accepted_next     = accepted_reg;
        mbits_next        = mbits_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        nsq_next          = nsq_reg;
        mrem_next         = mrem_reg;
        mean_next         = mean_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_accepted_next = out_accepted_reg;
        out_count_next    = out_count_reg;
        out_mean_next     = out_mean_reg;
        out_sd_next       = out_sd_reg;
        out_max_time_next = out_max_time_reg;
        out_max_wait_next = out_max_wait_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    t_next        = in_time;
                    accepted_next = !count_full;
                    prod_next     = '0;
                    if (!count_full)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(in_time);
                        if (in_time > max_time_reg)
                            max_time_next = in_time;
                        if (in_wait > max_wait_reg)
                            max_wait_next = in_wait;
                        mbits_next = SUM_W'(in_time) << (SUM_W - DATA_W);
                        step_next  = STEP_W'(DATA_W - 1);
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        // store full: statistics stand, go straight to sum^2
                        mbits_next = sum_reg;
                        mrem_next  = '0;
                        mean_next  = '0;
                        step_next  = STEP_W'(SUM_W - 1);
                        state_next = ST_MUL_SS;
                    end
                end
            end

            ST_SQUARE:
            begin
                prod_next  = prod_shift + (mbit ? NUM_W'(t_reg) : '0);
                mbits_next = {mbits_reg[SUM_W-2:0], 1'b0};
                if (step_reg == '0)
                    state_next = ST_ACCUM;
                else
                    step_next = step_reg - 1'b1;
            end

            ST_ACCUM:
            begin
                sumsq_next = sumsq_reg + SQ_W'(prod_reg[VAR_W-1:0]);
                prod_next  = '0;
                mbits_next = sum_reg;
                mrem_next  = '0;
                mean_next  = '0;
                step_next  = STEP_W'(SUM_W - 1);
                state_next = ST_MUL_SS;
            end

            ST_MUL_SS:
            begin
                prod_next  = prod_shift + (mbit ? NUM_W'(sum_reg) : '0);
                mrem_next  = mean_ge ? CNT_W'(mean_r - mean_d) : CNT_W'(mean_r);
                mean_next  = {mean_reg[DATA_W-2:0], mean_ge};
                mbits_next = {mbits_reg[SUM_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    acc_next   = '0;
                    nsq_next   = '0;
                    mbits_next = SUM_W'(count_reg) << (SUM_W - CNT_W);
                    step_next  = STEP_W'(CNT_W - 1);
                    state_next = ST_MUL_NS;
                end
                else
                    step_next = step_reg - 1'b1;
            end

            ST_MUL_NS:
            begin
                acc_next   = acc_shift + (mbit ? NUM_W'(sumsq_reg) : '0);
                nsq_next   = {nsq_reg[NSQ_W-2:0], 1'b0} + (mbit ? NSQ_W'(count_reg) : '0);
                mbits_next = {mbits_reg[SUM_W-2:0], 1'b0};
                if (step_reg == '0)
                    state_next = ST_SUB;
                else
                    step_next = step_reg - 1'b1;
            end

            ST_SUB:
            begin
                // variance is below 2^VAR_W, so the bits above VAR_W are
                // already a remainder below n^2 and need no steps
                if (num_ge)
                begin
                    rem_next = REM_W'(acc_reg[NUM_W-1:VAR_W] - prod_reg[NUM_W-1:VAR_W]
                               - NUM_W'(acc_reg[VAR_W-1:0] < prod_reg[VAR_W-1:0]));
                    acc_next = NUM_W'(acc_reg[VAR_W-1:0] - prod_reg[VAR_W-1:0]);
                end
                else
                begin
                    rem_next = '0;
                    acc_next = '0;
                end
                step_next  = STEP_W'(VAR_W - 1);
                state_next = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                rem_next = div_ge ? (div_r - div_d) : div_r;
                acc_next = NUM_W'({acc_reg[VAR_W-2:0], div_ge});
                if (step_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(DATA_W - 1);
                    state_next = ST_ROOT;
                end
                else
                    step_next = step_reg - 1'b1;
            end

            ST_ROOT:
            begin
                rem_next  = sqrt_ge ? (sqrt_r - sqrt_trial) : sqrt_r;
                root_next = {root_reg[DATA_W-2:0], sqrt_ge};
                acc_next  = NUM_W'({acc_reg[VAR_W-3:0], 2'b00});
                if (step_reg == '0)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg - 1'b1;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_accepted_next = accepted_reg;
                    out_count_next    = count_reg;
                    out_mean_next     = mean_reg;
                    out_sd_next       = root_reg;
                    out_max_time_next = max_time_reg;
                    out_max_wait_next = max_wait_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
            max_time_reg     <= '0;
            max_wait_reg     <= '0;
            t_reg            <= '0;
            accepted_reg     <= 1'b0;
            mbits_reg        <= '0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            nsq_reg          <= '0;
            mrem_reg         <= '0;
            mean_reg         <= '0;
            rem_reg          <= '0;
            root_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_accepted_reg <= 1'b0;
            out_count_reg    <= '0;
            out_mean_reg     <= '0;
            out_sd_reg       <= '0;
            out_max_time_reg <= '0;
            out_max_wait_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            sumsq_reg        <= sumsq_next;
            max_time_reg     <= max_time_next;
            max_wait_reg     <= max_wait_next;
            t_reg            <= t_next;
            accepted_reg     <= accepted_next;
            mbits_reg        <= mbits_next;
            prod_reg         <= prod_next;
            acc_reg          <= acc_next;
            nsq_reg          <= nsq_next;
            mrem_reg         <= mrem_next;
            mean_reg         <= mean_next;
            rem_reg          <= rem_next;
            root_reg         <= root_next;
            out_valid_reg    <= out_valid_next;
            out_accepted_reg <= out_accepted_next;
            out_count_reg    <= out_count_next;
            out_mean_reg     <= out_mean_next;
            out_sd_reg       <= out_sd_next;
            out_max_time_reg <= out_max_time_next;
            out_max_wait_reg <= out_max_wait_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_accepted_reg;
    assign m_tdata  = M_TDATA_W'({out_max_wait_reg, out_max_time_reg, out_sd_reg,
                                  out_mean_reg, out_count_reg});

    // a recorded sample bumps the count by one
    `RSS_ASSERT_NEXT(a_count_step, in_fire && !count_full, count_reg == $past(count_reg) + 1'b1, "count did not advance on a recorded sample")
    // a sample offered to a full store leaves the statistics alone
    `RSS_ASSERT_NEXT(a_full_hold, in_fire && count_full, $stable(count_reg) && $stable(sum_reg) && $stable(sumsq_reg), "full store changed its statistics")
    // every result follows at least one recorded sample
    `RSS_ASSERT_NOW(a_out_count, m_tvalid, out_count_reg != '0 && out_count_reg <= CNT_W'(MAX_SAMPLES), "result count out of range")
    // mean and deviation can never exceed the largest time
    `RSS_ASSERT_NOW(a_out_bounds, m_tvalid, out_mean_reg <= out_max_time_reg && out_sd_reg <= out_max_time_reg, "mean or deviation above maximum")

endmodule
